// ----- src/i2a_pkg.sv -----
// i2a_pkg: shared types and constants for the integer to ascii formatter
// no dependencies; imported by every other file of the block but i2a_stream_if
`default_nettype none

package i2a_pkg;

  localparam int OPER_W     = 32;  // operand register width
  localparam int NUM_DIGITS = 10;  // enough decimal digits for 32 bits
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int DIG_IDX_W  = 4;
  localparam int CONV_STEPS = OPER_W;
  localparam int CONV_CNT_W = 5;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A_UP  = 8'h41;
  localparam logic [7:0] CHAR_A_LO  = 8'h61;
  localparam logic [3:0] DIGIT_TEN  = 4'd10;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        long_operand;
    logic        radix_hex;
    logic        signed_mode;
    logic [5:0]  field_width;
    logic [1:0]  pad_mode;
    logic        upper_case;
  } i2a_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } i2a_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_PLAN,
    ST_START,
    ST_SIGN,
    ST_PADL,
    ST_MINUS,
    ST_DIGIT,
    ST_PADR
  } i2a_state_e;

  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_PAD,
    SEL_DIGIT
  } i2a_sel_e;

  typedef struct packed {
    logic     load;
    logic     conv_step;
    logic     size;
    logic     plan;
    logic     emit;
    i2a_sel_e sel;
  } i2a_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic sign_first;
    logic pad_left;
    logic neg_text;
    logic pad_trail;
    logic pad_last;
    logic dig_last;
  } i2a_sts_t;

endpackage

`default_nettype wire

// ----- src/i2a_stream_if.sv -----
// i2a_stream_if: valid/ready channel carrying one word of a payload type
// depends on nothing; payload types come from i2a_pkg at instantiation
`default_nettype none

interface i2a_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/i2a_ctrl.sv -----
// i2a_ctrl: sequencer for conversion, sizing and character emission
// depends on i2a_pkg
`default_nettype none

module i2a_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output i2a_pkg::i2a_cmd_t   cmd_o,
  input  wire i2a_pkg::i2a_sts_t sts_i
);
  import i2a_pkg::*;

  i2a_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       emit_ok;
  i2a_state_e aft_padl, aft_sign, aft_start, aft_digit;

  assign emit_ok = !out_valid_q || out_ready_i;

  // phase chain, skipping empty phases
  assign aft_padl  = sts_i.neg_text ? ST_MINUS : ST_DIGIT;
  assign aft_sign  = sts_i.pad_left ? ST_PADL : aft_padl;
  assign aft_start = sts_i.sign_first ? ST_SIGN : aft_sign;
  assign aft_digit = sts_i.pad_trail ? ST_PADR : ST_IDLE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CONV;
      ST_CONV:  if (sts_i.conv_last) state_d = ST_SIZE;
      ST_SIZE:  state_d = ST_PLAN;
      ST_PLAN:  state_d = ST_START;
      ST_START: state_d = aft_start;
      ST_SIGN:  if (emit_ok) state_d = aft_sign;
      ST_PADL:  if (emit_ok && sts_i.pad_last) state_d = aft_padl;
      ST_MINUS: if (emit_ok) state_d = ST_DIGIT;
      ST_DIGIT: if (emit_ok && sts_i.dig_last) state_d = aft_digit;
      ST_PADR:  if (emit_ok && sts_i.pad_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = SEL_DIGIT;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CONV: cmd_o.conv_step = 1'b1;
      ST_SIZE: cmd_o.size = 1'b1;
      ST_PLAN: cmd_o.plan = 1'b1;
      ST_SIGN, ST_MINUS: begin
        cmd_o.emit = emit_ok;
        cmd_o.sel  = SEL_MINUS;
      end
      ST_PADL, ST_PADR: begin
        cmd_o.emit = emit_ok;
        cmd_o.sel  = SEL_PAD;
      end
      ST_DIGIT: begin
        cmd_o.emit = emit_ok;
        cmd_o.sel  = SEL_DIGIT;
      end
      default: cmd_o.emit = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- src/i2a_datapath.sv -----
// i2a_datapath: operand capture, binary to bcd shifter, field sizing, char select
// depends on i2a_pkg; driven by i2a_ctrl commands
`default_nettype none

module i2a_datapath #(
  parameter int MAX_WIDTH   = 32,
  parameter int NARROW_BITS = 16,
  parameter int WIDE_BITS   = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire i2a_pkg::i2a_in_t  in_data_i,
  input  wire i2a_pkg::i2a_cmd_t cmd_i,
  output i2a_pkg::i2a_sts_t      sts_o,
  output i2a_pkg::i2a_out_t      out_data_o
);
  import i2a_pkg::*;

  localparam logic [OPER_W-1:0] NARROW_MASK = OPER_W'((64'd1 << NARROW_BITS) - 64'd1);
  localparam logic [OPER_W-1:0] WIDE_MASK   = OPER_W'((64'd1 << WIDE_BITS) - 64'd1);
  localparam logic [5:0]        WIDTH_CAP   = 6'(MAX_WIDTH);

  // operand capture
  logic [OPER_W-1:0] oper_mask, oper, magnitude;
  logic              oper_msb, is_neg;
  logic [5:0]        width_sat;

  always_comb begin
    oper_mask = in_data_i.long_operand ? WIDE_MASK : NARROW_MASK;
    oper      = in_data_i.value_bits & oper_mask;
    oper_msb  = in_data_i.long_operand ? in_data_i.value_bits[WIDE_BITS-1]
                                       : in_data_i.value_bits[NARROW_BITS-1];
    is_neg    = in_data_i.signed_mode && !in_data_i.radix_hex && oper_msb;
    magnitude = is_neg ? ((~oper + 1'b1) & oper_mask) : oper;
    width_sat = (in_data_i.field_width > WIDTH_CAP) ? WIDTH_CAP : in_data_i.field_width;
  end

  logic [OPER_W-1:0]     bin_q;
  logic [BCD_W-1:0]      bcd_q;
  logic                  hex_q, upper_q, neg_q;
  logic [1:0]            pad_q;
  logic [5:0]            width_q;
  logic [DIG_IDX_W-1:0]  nd_q;
  logic                  sign_first_q, neg_text_q, zero_pad_q, fill_nz_q;
  logic [5:0]            pad_cnt_q, rem_q;
  logic [DIG_IDX_W-1:0]  dig_idx_q;
  logic [CONV_CNT_W-1:0] conv_cnt_q;
  logic [7:0]            char_q;
  logic                  last_q;

  // shift-and-add-three step
  logic [BCD_W-1:0] bcd_adj;
  logic [3:0]       dgt;

  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dgt = bcd_q[4*i +: 4];
      bcd_adj[4*i +: 4] = (dgt >= 4'd5) ? dgt + 4'd3 : dgt;
    end
  end

  // top nonzero digit, at least one digit
  logic [DIG_IDX_W-1:0] nd_d;

  always_comb begin
    nd_d = DIG_IDX_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) nd_d = DIG_IDX_W'(i + 1);
    end
  end

  // field plan
  logic       sf_d, nt_d, zp_d;
  logic [5:0] w2_d, len_d, fill_d, total_d;

  always_comb begin
    sf_d    = neg_q && (width_q != 6'd0) && pad_q[1];
    nt_d    = neg_q && !sf_d;
    w2_d    = width_q - {5'd0, sf_d};
    len_d   = {2'd0, nd_q} + {5'd0, nt_d};
    fill_d  = (w2_d > len_d) ? w2_d - len_d : 6'd0;
    zp_d    = (w2_d != 6'd0) && pad_q[1];
    total_d = {5'd0, sf_d} + fill_d + len_d;
  end

  // character select
  logic [3:0] cur_dgt;
  logic [7:0] dgt_char, sel_char;

  always_comb begin
    cur_dgt = bcd_q[{dig_idx_q, 2'b00} +: 4];
    if (cur_dgt < DIGIT_TEN) begin
      dgt_char = CHAR_ZERO + {4'd0, cur_dgt};
    end else begin
      dgt_char = (upper_q ? CHAR_A_UP : CHAR_A_LO) + {4'd0, cur_dgt - DIGIT_TEN};
    end
    case (cmd_i.sel)
      SEL_MINUS: sel_char = CHAR_MINUS;
      SEL_PAD:   sel_char = zero_pad_q ? CHAR_ZERO : CHAR_SPACE;
      SEL_DIGIT: sel_char = dgt_char;
      default:   sel_char = CHAR_SPACE;
    endcase
  end

  // sequencing counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_cnt_q <= '0;
      pad_cnt_q  <= '0;
      dig_idx_q  <= '0;
      rem_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        conv_cnt_q <= CONV_CNT_W'(CONV_STEPS - 1);
      end else if (cmd_i.conv_step) begin
        conv_cnt_q <= conv_cnt_q - 1'b1;
      end
      if (cmd_i.plan) begin
        pad_cnt_q <= fill_d;
        dig_idx_q <= nd_q - 1'b1;
        rem_q     <= total_d;
      end else if (cmd_i.emit) begin
        rem_q <= rem_q - 1'b1;
        if (cmd_i.sel == SEL_PAD) pad_cnt_q <= pad_cnt_q - 1'b1;
        if (cmd_i.sel == SEL_DIGIT) dig_idx_q <= dig_idx_q - 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q   <= magnitude;
      bcd_q   <= in_data_i.radix_hex ? BCD_W'(magnitude) : '0;
      hex_q   <= in_data_i.radix_hex;
      upper_q <= in_data_i.upper_case;
      neg_q   <= is_neg;
      pad_q   <= in_data_i.pad_mode;
      width_q <= width_sat;
    end else if (cmd_i.conv_step && !hex_q) begin
      bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[OPER_W-1]};
      bin_q <= {bin_q[OPER_W-2:0], 1'b0};
    end
    if (cmd_i.size) nd_q <= nd_d;
    if (cmd_i.plan) begin
      sign_first_q <= sf_d;
      neg_text_q   <= nt_d;
      zero_pad_q   <= zp_d;
      fill_nz_q    <= (fill_d != 6'd0);
    end
    if (cmd_i.emit) begin
      char_q <= sel_char;
      last_q <= (rem_q == 6'd1);
    end
  end

  always_comb begin
    sts_o.conv_last  = hex_q || (conv_cnt_q == '0);
    sts_o.sign_first = sign_first_q;
    sts_o.pad_left   = !pad_q[0] && fill_nz_q;
    sts_o.neg_text   = neg_text_q;
    sts_o.pad_trail  = pad_q[0] && fill_nz_q;
    sts_o.pad_last   = (pad_cnt_q == 6'd1);
    sts_o.dig_last   = (dig_idx_q == '0);
  end

  assign out_data_o.character = char_q;
  assign out_data_o.last_char = last_q;

endmodule

`default_nettype wire

// ----- src/integer_to_padded_ascii.sv -----
// integer_to_padded_ascii: formats one integer word into a stream of ascii words
// decimal: 32 shift-and-add-three steps of the bcd converter, then sizing and planning; hex
//   does no shift steps; then one character per cycle while the output is not held back
// one item at a time, limited by the bcd shift loop and the single output register; next item
//   taken in idle after the last char; reset: rst_ni async active low clears the sequencer,
//   output valid and the datapath counters; payload data regs are not reset
`default_nettype none

module integer_to_padded_ascii #(
  parameter int MAX_WIDTH   = 32,
  parameter int NARROW_BITS = 16,
  parameter int WIDE_BITS   = 32
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  i2a_stream_if.sink   in_i,
  i2a_stream_if.source out_o
);
  import i2a_pkg::*;

  // command and status between sequencer and datapath
  i2a_cmd_t cmd;
  i2a_sts_t sts;

  // sequencer: owns input ready and the output valid flag
  i2a_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: operand capture, bcd conversion, field plan and output word register
  i2a_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .NARROW_BITS (NARROW_BITS),
    .WIDE_BITS   (WIDE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_o.data)
  );

`ifndef SYNTHESIS
  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted while previous item still in work");

  // characters of one number follow without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.data.last_char |=> out_o.valid)
    else $error("gap inside a formatted number");

  // only sign, pad and digit characters appear
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      (out_o.data.character == CHAR_MINUS) || (out_o.data.character == CHAR_SPACE) ||
      ((out_o.data.character >= 8'h30) && (out_o.data.character <= 8'h39)) ||
      ((out_o.data.character >= 8'h41) && (out_o.data.character <= 8'h46)) ||
      ((out_o.data.character >= 8'h61) && (out_o.data.character <= 8'h66)))
    else $error("unexpected output character");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_integer_to_padded_ascii.sv -----
// tb_integer_to_padded_ascii: self-checking testbench for the integer to ascii formatter
// depends on i2a_pkg, i2a_stream_if and integer_to_padded_ascii from src
// directed format cases, then random numbers under changing idle patterns on both channels
`default_nettype none

module tb_integer_to_padded_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  import i2a_pkg::*;

  // block parameters, kept at their defaults
  localparam int MAX_W   = 32;
  localparam int NARROW_W = 16;
  localparam int WIDE_W   = 32;

  // format field codes
  localparam bit OPER_NARROW = 1'b0;
  localparam bit OPER_LONG   = 1'b1;
  localparam bit RADIX_DEC   = 1'b0;
  localparam bit RADIX_HEX   = 1'b1;
  localparam bit AS_UNSIGNED = 1'b0;
  localparam bit AS_SIGNED   = 1'b1;
  localparam bit HEX_LOWER   = 1'b0;
  localparam bit HEX_UPPER   = 1'b1;

  localparam logic [1:0] PAD_SPACE_LEFT  = 2'b00;
  localparam logic [1:0] PAD_SPACE_RIGHT = 2'b01;
  localparam logic [1:0] PAD_ZERO_LEFT   = 2'b10;
  localparam logic [1:0] PAD_ZERO_RIGHT  = 2'b11;
  localparam int PAD_TRAIL_BIT = 0;
  localparam int PAD_ZERO_BIT  = 1;

  // quiet cycles allowed before the run is declared hung; set well above the decimal
  // setup of the bcd shift loop, so this leaves a wide margin for stalls
  localparam int QUIET_LIMIT  = 2000;
  // cycles watched after the last expected word, in case stray words follow
  localparam int DRAIN_CYCLES = 100;

  logic clk_i;
  logic rst_ni;

  i2a_stream_if #(.payload_t(i2a_in_t))  number_if ();
  i2a_stream_if #(.payload_t(i2a_out_t)) text_if ();

  integer_to_padded_ascii #(
    .MAX_WIDTH  (MAX_W),
    .NARROW_BITS(NARROW_W),
    .WIDE_BITS  (WIDE_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (number_if),
    .out_o (text_if)
  );

  // characters still owed by the block, oldest first
  i2a_out_t expected_chars[$];
  int       mismatches;
  int       quiet_cycles;
  // idle chance per cycle, in percent, for the sender and the receiver
  int       tx_idle_pct;
  int       rx_idle_pct;

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // predictor: computes the text of one number and queues it, last char marked
  // ---------------------------------------------------------------------------
  task automatic predict_text(input i2a_in_t w);
    int unsigned nbits;
    int unsigned base;
    int unsigned width;
    int unsigned fill;
    logic [63:0] mag;
    logic [63:0] mask;
    logic [7:0]  digit;
    logic [7:0]  padc;
    logic [7:0]  body[$];
    logic [7:0]  line[$];
    bit          neg;
    i2a_out_t    ch;

    nbits = w.long_operand ? WIDE_W : NARROW_W;
    base  = w.radix_hex ? 16 : 10;
    width = (w.field_width > MAX_W) ? MAX_W : w.field_width;
    mask  = (64'd1 << nbits) - 64'd1;
    mag   = {32'b0, w.value_bits} & mask;

    // two's complement only counts in decimal
    neg = w.signed_mode && !w.radix_hex && mag[nbits-1];
    if (neg) begin
      mag = ((64'd1 << nbits) - mag) & mask;
    end

    // digits, most significant first; zero still yields one digit
    do begin
      digit = 8'(mag % 64'(base));
      if (digit >= DIGIT_TEN) begin
        body.push_front((w.upper_case ? CHAR_A_UP : CHAR_A_LO) + digit - 8'(DIGIT_TEN));
      end else begin
        body.push_front(CHAR_ZERO + digit);
      end
      mag = mag / 64'(base);
    end while (mag != 0);

    // with zeros and a width the sign leads and eats one column of the field
    if (neg) begin
      if (width != 0 && w.pad_mode[PAD_ZERO_BIT]) begin
        line.push_back(CHAR_MINUS);
        width--;
      end else begin
        body.push_front(CHAR_MINUS);
      end
    end

    padc = (width > 0 && w.pad_mode[PAD_ZERO_BIT]) ? CHAR_ZERO : CHAR_SPACE;
    fill = (body.size() >= width) ? 0 : width - body.size();

    if (!w.pad_mode[PAD_TRAIL_BIT]) begin
      repeat (fill) line.push_back(padc);
    end
    foreach (body[i]) line.push_back(body[i]);
    if (w.pad_mode[PAD_TRAIL_BIT]) begin
      repeat (fill) line.push_back(padc);
    end

    foreach (line[i]) begin
      ch.character = line[i];
      ch.last_char = (i == line.size() - 1);
      expected_chars.push_back(ch);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender: presents one number word and waits for it to be taken
  // entered and left just after a rising edge, so valid gets one update per step
  // ---------------------------------------------------------------------------
  task automatic send_number(input i2a_in_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      number_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    number_if.valid <= 1'b1;
    number_if.data  <= w;
    @(posedge clk_i);
    while (!number_if.ready) @(posedge clk_i);
    // taken at this edge: the text it owes joins the queue
    predict_text(w);
  endtask

  function automatic i2a_in_t make_number(input logic [31:0] value, input bit wide,
                                          input bit hex, input bit sgn,
                                          input logic [5:0] width, input logic [1:0] pad,
                                          input bit upper);
    i2a_in_t w;
    w.value_bits   = value;
    w.long_operand = wide;
    w.radix_hex    = hex;
    w.signed_mode  = sgn;
    w.field_width  = width;
    w.pad_mode     = pad;
    w.upper_case   = upper;
    return w;
  endfunction

  // random number word; values lean toward zero, small magnitudes and the extremes
  function automatic i2a_in_t random_number(input bit wide);
    i2a_in_t w;
    w.long_operand = wide;
    w.radix_hex    = 1'($urandom_range(1));
    w.signed_mode  = 1'($urandom_range(1));
    w.pad_mode     = 2'($urandom_range(3));
    w.upper_case   = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       w.value_bits = 32'd0;
      1, 2:    w.value_bits = $urandom_range(999);
      3:       w.value_bits = -$urandom_range(999);
      4: begin
        case ($urandom_range(3))
          0:       w.value_bits = 32'h0000_8000;
          1:       w.value_bits = 32'h0000_FFFF;
          2:       w.value_bits = 32'h8000_0000;
          default: w.value_bits = 32'hFFFF_FFFF;
        endcase
      end
      default: w.value_bits = $urandom;
    endcase
    // widths mostly near the text length, sometimes beyond saturation
    case ($urandom_range(7))
      0:       w.field_width = 6'd0;
      1:       w.field_width = 6'($urandom_range(63));
      default: w.field_width = 6'($urandom_range(16));
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes and every special formatting case
  task automatic test_directed_formats();
    // zero is always "0", never signed, padded as usual
    send_number(make_number(32'd0, OPER_NARROW, RADIX_DEC, AS_SIGNED, 6'd0,
                            PAD_SPACE_LEFT, HEX_LOWER));
    send_number(make_number(32'd0, OPER_LONG, RADIX_HEX, AS_UNSIGNED, 6'd5,
                            PAD_ZERO_LEFT, HEX_UPPER));
    send_number(make_number(32'd0, OPER_NARROW, RADIX_DEC, AS_SIGNED, 6'd4,
                            PAD_SPACE_RIGHT, HEX_LOWER));
    // narrow and wide extremes, signed and unsigned
    send_number(make_number(32'h0000_FFFF, OPER_NARROW, RADIX_DEC, AS_UNSIGNED, 6'd0,
                            PAD_SPACE_LEFT, HEX_LOWER));
    send_number(make_number(32'hFFFF_FFFF, OPER_NARROW, RADIX_DEC, AS_SIGNED, 6'd0,
                            PAD_SPACE_LEFT, HEX_LOWER));
    send_number(make_number(32'h0000_8000, OPER_NARROW, RADIX_DEC, AS_SIGNED, 6'd0,
                            PAD_SPACE_LEFT, HEX_LOWER));
    send_number(make_number(32'h8000_0000, OPER_LONG, RADIX_DEC, AS_SIGNED, 6'd0,
                            PAD_SPACE_LEFT, HEX_LOWER));
    send_number(make_number(32'hFFFF_FFFF, OPER_LONG, RADIX_DEC, AS_UNSIGNED, 6'd0,
                            PAD_SPACE_LEFT, HEX_LOWER));
    send_number(make_number(32'hFFFF_FFFF, OPER_LONG, RADIX_HEX, AS_UNSIGNED, 6'd0,
                            PAD_SPACE_LEFT, HEX_UPPER));
    send_number(make_number(32'hABCD_EF01, OPER_LONG, RADIX_HEX, AS_UNSIGNED, 6'd12,
                            PAD_SPACE_RIGHT, HEX_LOWER));
    // sign flag has no effect in hex
    send_number(make_number(32'h0000_8000, OPER_NARROW, RADIX_HEX, AS_SIGNED, 6'd0,
                            PAD_SPACE_LEFT, HEX_UPPER));
    // bits above a narrow operand are dropped
    send_number(make_number(32'hDEAD_1234, OPER_NARROW, RADIX_HEX, AS_UNSIGNED, 6'd6,
                            PAD_ZERO_LEFT, HEX_LOWER));
    // negative with zero padding: sign first, then zeros on either side
    send_number(make_number(32'hFFFF_FF85, OPER_LONG, RADIX_DEC, AS_SIGNED, 6'd8,
                            PAD_ZERO_LEFT, HEX_LOWER));
    send_number(make_number(32'hFFFF_FF85, OPER_LONG, RADIX_DEC, AS_SIGNED, 6'd8,
                            PAD_ZERO_RIGHT, HEX_LOWER));
    send_number(make_number(32'hFFFF_FF85, OPER_LONG, RADIX_DEC, AS_SIGNED, 6'd1,
                            PAD_ZERO_LEFT, HEX_LOWER));
    // zero padding without a width: sign stays part of the text
    send_number(make_number(32'hFFFF_FF85, OPER_LONG, RADIX_DEC, AS_SIGNED, 6'd0,
                            PAD_ZERO_LEFT, HEX_LOWER));
    // negative with spaces: padding goes around the signed text
    send_number(make_number(32'h0000_FF85, OPER_NARROW, RADIX_DEC, AS_SIGNED, 6'd10,
                            PAD_SPACE_LEFT, HEX_LOWER));
    send_number(make_number(32'h0000_FF85, OPER_NARROW, RADIX_DEC, AS_SIGNED, 6'd10,
                            PAD_SPACE_RIGHT, HEX_LOWER));
    // widths past the maximum saturate; then fields of exactly the maximum width
    send_number(make_number(32'd42, OPER_LONG, RADIX_DEC, AS_UNSIGNED, 6'd63,
                            PAD_ZERO_LEFT, HEX_LOWER));
    send_number(make_number(32'd42, OPER_LONG, RADIX_DEC, AS_UNSIGNED, 6'd33,
                            PAD_SPACE_RIGHT, HEX_LOWER));
    send_number(make_number(32'hFFFF_FFFF, OPER_LONG, RADIX_DEC, AS_SIGNED, 6'd32,
                            PAD_ZERO_RIGHT, HEX_LOWER));
    send_number(make_number(32'h8000_0000, OPER_LONG, RADIX_DEC, AS_SIGNED, 6'd32,
                            PAD_ZERO_LEFT, HEX_LOWER));
    // text wider than the field gets no padding; then text just narrower than the field
    send_number(make_number(32'hFFFF_FFFF, OPER_LONG, RADIX_DEC, AS_UNSIGNED, 6'd3,
                            PAD_SPACE_LEFT, HEX_LOWER));
    send_number(make_number(32'h7FFF_FFFF, OPER_LONG, RADIX_DEC, AS_SIGNED, 6'd11,
                            PAD_SPACE_LEFT, HEX_UPPER));
    send_number(make_number(32'h5555_AAAA, OPER_NARROW, RADIX_DEC, AS_UNSIGNED, 6'd7,
                            PAD_ZERO_RIGHT, HEX_LOWER));
  endtask

  task automatic test_random_narrow(input int count);
    repeat (count) send_number(random_number(OPER_NARROW));
  endtask

  task automatic test_random_wide(input int count);
    repeat (count) send_number(random_number(OPER_LONG));
  endtask

  task automatic test_random_mixed(input int count);
    repeat (count) send_number(random_number(1'($urandom_range(1))));
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure on the text channel
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    text_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // checker: every accepted char against the oldest one owed
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    i2a_out_t want;
    if (rst_ni && text_if.valid && text_if.ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual char %h last %b", $time,
                 text_if.data.character, text_if.data.last_char);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (text_if.data.character !== want.character) begin
          $display("%0t: char mismatch: expected %h, actual %h", $time, want.character,
                   text_if.data.character);
          mismatches++;
        end
        if (text_if.data.last_char !== want.last_char) begin
          $display("%0t: last flag mismatch: expected %b, actual %b", $time,
                   want.last_char, text_if.data.last_char);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends a run in which neither channel moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (number_if.valid && number_if.ready) || (text_if.valid && text_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    number_if.valid = 1'b0;
    number_if.data  = '0;
    text_if.ready   = 1'b0;
    mismatches      = 0;
    quiet_cycles    = 0;
    // sender idles less than the receiver first
    tx_idle_pct     = 37;
    rx_idle_pct     = 51;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_formats();
    test_random_narrow(120);

    // swap the idle pattern
    tx_idle_pct = 51;
    rx_idle_pct = 37;
    test_random_wide(120);

    // full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_mixed(105);

    number_if.valid <= 1'b0;

    // drain, then watch for stray words; the watchdog bounds the wait
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
